### rtl/gcm_pkg.sv
`timescale 1ns / 1ps
package gcm_pkg;

    // Stop register packing: position above, four channel bytes below
    localparam int STOP_W        = 45;
    localparam int POS_LSB       = 32;
    localparam int POS_FIELD_W   = 13;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 4;
    localparam int NUM_STOP_REGS = 4;
    localparam int CNT_W         = 3;
    localparam int SAMPLE_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd4;

    // Reset gradient: blue, green, red, white
    localparam logic [STOP_W-1:0] RST_STOP_ZERO  = 45'd65535;
    localparam logic [STOP_W-1:0] RST_STOP_ONE   = 45'd5278531518719;
    localparam logic [STOP_W-1:0] RST_STOP_TWO   = 45'd10561307803903;
    localparam logic [STOP_W-1:0] RST_STOP_THREE = 45'd17596481011711;
    localparam logic [CNT_W-1:0]  RST_STOP_COUNT = 3'd4;

    // Side data carried through the divider: found, negative, base channel
    localparam int TAG_W = CHAN_W + 2;

    // Quotient bits resolved per divider stage
    localparam int DIV_BPS = 2;

    typedef logic [STOP_W-1:0] t_stop;

    // Channel byte of a stop: red first
    function automatic logic [CHAN_W-1:0] stop_chan(input t_stop s, input int ch);
        return s[(NUM_CHAN-1-ch)*CHAN_W +: CHAN_W];
    endfunction

endpackage

### rtl/gcm_sample_if.sv
`timescale 1ns / 1ps
interface gcm_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [gcm_pkg::SAMPLE_W-1:0] sample;
    modport source(output valid, output sample, input ready);
    modport sink(input valid, input sample, output ready);
endinterface

### rtl/gcm_color_if.sv
`timescale 1ns / 1ps
interface gcm_color_if;
    logic                        valid;
    logic                        ready;
    logic [gcm_pkg::CHAN_W-1:0] red;
    logic [gcm_pkg::CHAN_W-1:0] green;
    logic [gcm_pkg::CHAN_W-1:0] blue;
    logic [gcm_pkg::CHAN_W-1:0] alpha;
    modport source(output valid, output red, output green, output blue, output alpha,
                   input ready);
    modport sink(input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

### rtl/gcm_cfg_if.sv
`timescale 1ns / 1ps
interface gcm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gcm_pkg::CFG_IDX_W-1:0] index;
    logic [gcm_pkg::STOP_W-1:0]    data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/gcm_front.sv
`timescale 1ns / 1ps
// Front of the pipeline: clamp and segment search, differences, products, magnitudes
module gcm_front #(
    parameter int MAX_STOPS = 4,
    parameter int FRAC      = 12,
    parameter int PW        = FRAC + 1,
    parameter int MW        = PW + 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic signed [gcm_pkg::SAMPLE_W-1:0]        i_sample,
    input  gcm_pkg::t_stop [gcm_pkg::NUM_STOP_REGS-1:0] i_stops,
    input  logic [gcm_pkg::CNT_W-1:0]                  i_stop_count,
    output logic                                        o_valid,
    output logic                                        o_found,
    output logic [gcm_pkg::NUM_CHAN-1:0]               o_neg,
    output logic [gcm_pkg::NUM_CHAN-1:0][MW-1:0]       o_mag,
    output logic [PW-1:0]                               o_dmag,
    output logic [gcm_pkg::NUM_CHAN-1:0][gcm_pkg::CHAN_W-1:0] o_c0
);
    localparam int NCH  = gcm_pkg::NUM_CHAN;
    localparam int CW   = gcm_pkg::CHAN_W;
    localparam int XW   = PW + 1;
    localparam int PRW  = XW + CW + 1;
    localparam int SXW  = PW + gcm_pkg::SAMPLE_W + 1;
    localparam int FLDW = (PW < gcm_pkg::POS_FIELD_W) ? PW : gcm_pkg::POS_FIELD_W;
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC;

    function automatic logic [PW-1:0] stop_pos(input gcm_pkg::t_stop s);
        return PW'(s[gcm_pkg::POS_LSB +: FLDW]);
    endfunction

    // Stage A: clamp sample and pick the first qualifying segment
    logic                r_a_v, r_a_found;
    logic [PW-1:0]       r_a_p;
    gcm_pkg::t_stop      r_a_lo, r_a_hi;
    logic [PW-1:0]       n_p;
    logic                n_found;
    gcm_pkg::t_stop      n_lo, n_hi;

    always_comb begin
        logic signed [SXW-1:0]     sx;
        logic [gcm_pkg::CNT_W:0]   lim;
        sx  = SXW'(i_sample);
        lim = {1'b0, i_stop_count};
        if (sx < $signed(SXW'(0))) begin
            n_p = '0;
        end else if (sx > $signed(SXW'(ONE))) begin
            n_p = ONE;
        end else begin
            n_p = sx[PW-1:0];
        end
        if (int'(lim) > MAX_STOPS) lim = (gcm_pkg::CNT_W+1)'(MAX_STOPS);
        if (int'(lim) > gcm_pkg::NUM_STOP_REGS) lim = (gcm_pkg::CNT_W+1)'(gcm_pkg::NUM_STOP_REGS);
        n_found = 1'b0;
        n_lo    = i_stops[0];
        n_hi    = i_stops[1];
        for (int k = 0; k < gcm_pkg::NUM_STOP_REGS - 1; k++) begin
            if (!n_found && (k + 1 < int'(lim)) && (stop_pos(i_stops[k+1]) >= n_p)) begin
                n_found = 1'b1;
                n_lo    = i_stops[k];
                n_hi    = i_stops[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a_found <= n_found;
            r_a_p     <= n_p;
            r_a_lo    <= n_lo;
            r_a_hi    <= n_hi;
        end
    end

    // Stage B: offset, width and channel differences
    logic                          r_b_v, r_b_found;
    logic signed [XW-1:0]          r_b_off, r_b_d;
    logic signed [NCH-1:0][CW:0]   r_b_dc;
    logic [NCH-1:0][CW-1:0]        r_b_c0;
    logic signed [XW-1:0]          n_d;

    always_comb begin
        n_d = $signed({1'b0, stop_pos(r_a_hi)}) - $signed({1'b0, stop_pos(r_a_lo)});
        if (n_d == '0) n_d = $signed({1'b0, ONE});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            r_b_found <= r_a_found;
            r_b_off   <= $signed({1'b0, r_a_p}) - $signed({1'b0, stop_pos(r_a_lo)});
            r_b_d     <= n_d;
            for (int c = 0; c < NCH; c++) begin
                r_b_dc[c] <= $signed({1'b0, gcm_pkg::stop_chan(r_a_hi, c)})
                           - $signed({1'b0, gcm_pkg::stop_chan(r_a_lo, c)});
                r_b_c0[c] <= gcm_pkg::stop_chan(r_a_lo, c);
            end
        end
    end

    // Stage C: one product per channel
    logic                          r_c_v, r_c_found, r_c_dneg;
    logic [PW-1:0]                 r_c_dmag;
    logic signed [NCH-1:0][PRW-1:0] r_c_prod;
    logic [NCH-1:0][CW-1:0]        r_c_c0;
    logic signed [XW-1:0]          n_dneg_val;

    assign n_dneg_val = -r_b_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
        if (i_en) begin
            r_c_found <= r_b_found;
            r_c_dneg  <= r_b_d[XW-1];
            r_c_dmag  <= r_b_d[XW-1] ? n_dneg_val[PW-1:0] : r_b_d[PW-1:0];
            r_c_c0    <= r_b_c0;
            for (int c = 0; c < NCH; c++) begin
                r_c_prod[c] <= $signed({{(PRW-XW){r_b_off[XW-1]}}, r_b_off})
                             * $signed({{(PRW-CW-1){r_b_dc[c][CW]}}, r_b_dc[c]});
            end
        end
    end

    // Stage D: numerator magnitudes and quotient signs
    logic                          r_d_v, r_d_found;
    logic [NCH-1:0]                r_d_neg;
    logic [NCH-1:0][MW-1:0]        r_d_mag;
    logic [PW-1:0]                 r_d_dmag;
    logic [NCH-1:0][CW-1:0]        r_d_c0;
    logic [NCH-1:0][PRW-1:0]       n_pabs;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_pabs[c] = r_c_prod[c][PRW-1] ? PRW'(-r_c_prod[c]) : PRW'(r_c_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_d_v <= r_c_v;
        end
        if (i_en) begin
            r_d_found <= r_c_found;
            r_d_dmag  <= r_c_dmag;
            r_d_c0    <= r_c_c0;
            for (int c = 0; c < NCH; c++) begin
                r_d_neg[c] <= r_c_prod[c][PRW-1] ^ r_c_dneg;
                r_d_mag[c] <= n_pabs[c][MW-1:0];
            end
        end
    end

    assign o_valid = r_d_v;
    assign o_found = r_d_found;
    assign o_neg   = r_d_neg;
    assign o_mag   = r_d_mag;
    assign o_dmag  = r_d_dmag;
    assign o_c0    = r_d_c0;

endmodule

### rtl/gcm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, a few quotient bits per stage
module gcm_div #(
    parameter int PW = 13,
    parameter int MW = PW + 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [MW-1:0]              i_num,
    input  logic [PW-1:0]              i_den,
    input  logic [gcm_pkg::TAG_W-1:0]  i_tag,
    output logic                       o_valid,
    output logic [MW-1:0]              o_quo,
    output logic                       o_rem_nz,
    output logic [gcm_pkg::TAG_W-1:0]  o_tag
);
    localparam int BPS = gcm_pkg::DIV_BPS;
    localparam int DS  = (MW + BPS - 1) / BPS;

    logic                       r_v   [DS];
    logic [MW-1:0]              r_nq  [DS];
    logic [PW-1:0]              r_rem [DS];
    logic [PW-1:0]              r_den [DS];
    logic [gcm_pkg::TAG_W-1:0]  r_tag [DS];

    for (genvar s = 0; s < DS; s++) begin : g_st
        logic                       src_v;
        logic [MW-1:0]              src_nq;
        logic [PW-1:0]              src_rem;
        logic [PW-1:0]              src_den;
        logic [gcm_pkg::TAG_W-1:0]  src_tag;
        logic [MW-1:0]              n_nq;
        logic [PW-1:0]              n_rem;

        if (s == 0) begin : g_head
            assign src_v   = i_valid;
            assign src_nq  = i_num;
            assign src_rem = '0;
            assign src_den = i_den;
            assign src_tag = i_tag;
        end else begin : g_body
            assign src_v   = r_v[s-1];
            assign src_nq  = r_nq[s-1];
            assign src_rem = r_rem[s-1];
            assign src_den = r_den[s-1];
            assign src_tag = r_tag[s-1];
        end

        // Shift in DIV_BPS numerator bits one at a time, subtracting when the divisor fits
        always_comb begin
            logic [PW:0] t;
            n_nq  = src_nq;
            n_rem = src_rem;
            for (int j = 0; j < BPS; j++) begin
                if (s * BPS + j < MW) begin
                    t    = {n_rem, n_nq[MW-1]};
                    n_nq = {n_nq[MW-2:0], 1'b0};
                    if (t >= {1'b0, src_den}) begin
                        t       = t - {1'b0, src_den};
                        n_nq[0] = 1'b1;
                    end
                    n_rem = t[PW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= src_v;
            end
            if (i_en) begin
                r_nq[s]  <= n_nq;
                r_rem[s] <= n_rem;
                r_den[s] <= src_den;
                r_tag[s] <= src_tag;
            end
        end
    end

    assign o_valid  = r_v[DS-1];
    assign o_quo    = r_nq[DS-1];
    assign o_rem_nz = |r_rem[DS-1];
    assign o_tag    = r_tag[DS-1];

endmodule

### rtl/gradient_color_map_core.sv
`timescale 1ns / 1ps
// Gradient color map: each signed Q12 sample is clamped to 0..1.0 and mapped to RGBA by
// linear interpolation between the first pair of configured stops whose upper position is
// at or above it; with no such pair the color is opaque black. The block takes one sample
// every clock while the output is not stalled, through four front stages, the restoring
// divider of ceil((POSITION_FRACTION_BITS + 9) / 2) stages at two quotient bits each,
// and the output register. A stall at the output holds the whole pipeline. Stops are
// written through the configuration channel, which is always ready; write them only
// while no sample is in flight.
module gradient_color_map_core #(
    parameter int MAX_STOPS              = 4,
    parameter int POSITION_FRACTION_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gcm_sample_if.sink    i_sample_ch,
    gcm_color_if.source   o_color_ch,
    gcm_cfg_if.sink       i_cfg_ch
);
    localparam int PW  = POSITION_FRACTION_BITS + 1;
    localparam int MW  = PW + 8;
    localparam int NCH = gcm_pkg::NUM_CHAN;
    localparam int CW  = gcm_pkg::CHAN_W;
    localparam int VW  = MW + 3;

    // Configuration registers
    gcm_pkg::t_stop [gcm_pkg::NUM_STOP_REGS-1:0] r_stops;
    logic [gcm_pkg::CNT_W-1:0]                   r_count;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stops[0] <= gcm_pkg::RST_STOP_ZERO;
            r_stops[1] <= gcm_pkg::RST_STOP_ONE;
            r_stops[2] <= gcm_pkg::RST_STOP_TWO;
            r_stops[3] <= gcm_pkg::RST_STOP_THREE;
            r_count    <= gcm_pkg::RST_STOP_COUNT;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                gcm_pkg::REG_STOP_ZERO:  r_stops[0] <= i_cfg_ch.data;
                gcm_pkg::REG_STOP_ONE:   r_stops[1] <= i_cfg_ch.data;
                gcm_pkg::REG_STOP_TWO:   r_stops[2] <= i_cfg_ch.data;
                gcm_pkg::REG_STOP_THREE: r_stops[3] <= i_cfg_ch.data;
                gcm_pkg::REG_STOP_COUNT: r_count    <= i_cfg_ch.data[gcm_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the pipeline unless a finished item waits
    logic r_ov;
    logic w_en;
    assign w_en              = !r_ov || o_color_ch.ready;
    assign i_sample_ch.ready = w_en;

    logic                    f_valid, f_found;
    logic [NCH-1:0]          f_neg;
    logic [NCH-1:0][MW-1:0]  f_mag;
    logic [PW-1:0]           f_dmag;
    logic [NCH-1:0][CW-1:0]  f_c0;

    gcm_front #(
        .MAX_STOPS(MAX_STOPS),
        .FRAC     (POSITION_FRACTION_BITS),
        .PW       (PW),
        .MW       (MW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_sample_ch.valid),
        .i_sample    (i_sample_ch.sample),
        .i_stops     (r_stops),
        .i_stop_count(r_count),
        .o_valid     (f_valid),
        .o_found     (f_found),
        .o_neg       (f_neg),
        .o_mag       (f_mag),
        .o_dmag      (f_dmag),
        .o_c0        (f_c0)
    );

    // One divider lane per channel
    logic [NCH-1:0]                     d_valid;
    logic [NCH-1:0][MW-1:0]             d_quo;
    logic [NCH-1:0]                     d_rnz;
    logic [NCH-1:0][gcm_pkg::TAG_W-1:0] d_tag;

    for (genvar c = 0; c < NCH; c++) begin : g_lane
        gcm_div #(
            .PW(PW),
            .MW(MW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (f_valid),
            .i_num   (f_mag[c]),
            .i_den   (f_dmag),
            .i_tag   ({f_found, f_neg[c], f_c0[c]}),
            .o_valid (d_valid[c]),
            .o_quo   (d_quo[c]),
            .o_rem_nz(d_rnz[c]),
            .o_tag   (d_tag[c])
        );
    end

    // Apply floor sign, add base channel, saturate
    logic [NCH-1:0][CW-1:0] n_chan;
    logic                   n_found;

    always_comb begin
        logic signed [VW-1:0] q;
        logic signed [VW-1:0] v;
        n_found = d_tag[0][CW+1];
        for (int c = 0; c < NCH; c++) begin
            q = $signed({3'b000, d_quo[c]});
            if (d_tag[c][CW]) q = -(q + $signed(VW'(d_rnz[c])));
            v = q + $signed({{(VW-CW){1'b0}}, d_tag[c][CW-1:0]});
            if (v < $signed(VW'(0))) begin
                n_chan[c] = '0;
            end else if (v > $signed(VW'(255))) begin
                n_chan[c] = '1;
            end else begin
                n_chan[c] = v[CW-1:0];
            end
        end
    end

    // Output register
    logic [CW-1:0] r_red, r_green, r_blue, r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= &d_valid;
        end
        if (w_en) begin
            if (n_found) begin
                r_red   <= n_chan[0];
                r_green <= n_chan[1];
                r_blue  <= n_chan[2];
                r_alpha <= n_chan[3];
            end else begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
                r_alpha <= '1;
            end
        end
    end

    assign o_color_ch.valid = r_ov;
    assign o_color_ch.red   = r_red;
    assign o_color_ch.green = r_green;
    assign o_color_ch.blue  = r_blue;
    assign o_color_ch.alpha = r_alpha;

endmodule
